[hw/rtl/sorted_priority_queue_defines.svh]
// Assertion macros shared by the sorted priority queue RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/spq_pkg.sv]
// Package for the sorted priority queue: codes, cell control struct, defaults.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int SPQ_CAPACITY = 16;
    localparam int SPQ_DATA_W   = 32;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_FIND   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CMP,
        PH_UPD
    } phase_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    typedef struct packed {
        logic     cmp_en;
        cell_op_t op;
    } cell_ctrl_t;

endpackage

[hw/rtl/spq_cell.sv]
// One slot of the sorted chain: holds an entry and its compare flags.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  spq_pkg::cell_ctrl_t               ctrl,
    input  logic                              occupied,
    input  logic signed [spq_pkg::SPQ_DATA_W-1:0] cmp_key,
    input  logic signed [spq_pkg::SPQ_DATA_W-1:0] ins_key,
    input  logic signed [spq_pkg::SPQ_DATA_W-1:0] left_entry,
    input  logic                              left_ge,
    input  logic signed [spq_pkg::SPQ_DATA_W-1:0] right_entry,
    output logic signed [spq_pkg::SPQ_DATA_W-1:0] entry,
    output logic signed [spq_pkg::SPQ_DATA_W-1:0] entry_next,
    output logic                              ge,
    output logic                              eq
);
    import spq_pkg::*;

    logic signed [SPQ_DATA_W-1:0] entry_reg;
    logic                         ge_reg;
    logic                         eq_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (ge_reg)
                begin
                    entry_next = left_ge ? left_entry : ins_key;
                end
            end
            OP_REMOVE:
            begin
                if (ge_reg)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // ge: first cell at or past the key starts the boundary (empty slots count as ge)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ge_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            ge_reg <= !occupied || (entry_reg >= cmp_key);
            eq_reg <= occupied && (entry_reg == cmp_key);
        end
    end

    assign entry = entry_reg;
    assign ge    = ge_reg;
    assign eq    = eq_reg;

endmodule

[hw/rtl/sorted_priority_queue.sv]
// Top level of the sorted priority queue: command FSM, chain of cells, results.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_defines.svh.
//
// channel   direction  handshake             payload
// request   in         start & !busy         action, value
// result    out        done (one cycle)      status, position, head_value,
//                                            head_valid, entry_count
//
// A request has a compare phase, which compares the key in every cell, and an
// update phase, which shifts the chain and registers the result and done. busy
// is high only in compare, so a new request can be taken during the update phase.
// Reset empties the store at once; entry contents are not cleared.
// The result receiver cannot stall; results are never held back.
`timescale 1ns / 1ps
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            action,
    input  logic signed [spq_pkg::SPQ_DATA_W-1:0] value,
    output logic                                  done,
    output logic [1:0]                            status,
    output logic [3:0]                            position,
    output logic signed [spq_pkg::SPQ_DATA_W-1:0] head_value,
    output logic                                  head_valid,
    output logic [4:0]                            entry_count
);
    import spq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    phase_t phase_reg, phase_next;
    logic   accept;

    logic signed [SPQ_DATA_W-1:0] key_reg;
    logic [1:0]                   act_reg;
    logic signed [SPQ_DATA_W-1:0] upd_key_reg;
    logic [1:0]                   upd_act_reg;
    logic [CW-1:0]                count_reg, count_next;

    logic                         done_reg;
    status_t                      status_reg, status_next;
    logic [IW-1:0]                pos_reg, pos_next;
    logic signed [SPQ_DATA_W-1:0] head_reg, head_next;
    logic                         hvalid_reg;

    cell_ctrl_t ctrl;
    cell_op_t   op_upd;

    logic signed [SPQ_DATA_W-1:0] ent      [CAPACITY];
    logic signed [SPQ_DATA_W-1:0] ent_next [CAPACITY];
    logic [CAPACITY-1:0]          ge_vec;
    logic [CAPACITY-1:0]          eq_vec;
    logic [CAPACITY-1:0]          bnd_vec;
    logic                         found;
    logic [IW-1:0]                bnd_idx;

    logic [IW+3:0]                pos_wide;
    logic [CW+4:0]                cnt_wide;

    assign accept = start && !busy;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE: phase_next = start ? PH_CMP : PH_IDLE;
            PH_CMP:  phase_next = PH_UPD;
            PH_UPD:  phase_next = start ? PH_CMP : PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    // outputs of the FSM
    always_comb
    begin
        busy        = 1'b0;
        ctrl.cmp_en = 1'b0;
        ctrl.op     = OP_HOLD;
        case (phase_reg)
            PH_CMP:
            begin
                busy        = 1'b1;
                ctrl.cmp_en = 1'b1;
            end
            PH_UPD:
            begin
                ctrl.op = op_upd;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == PH_UPD);
            if (phase_reg == PH_UPD)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= value;
            act_reg <= action;
        end
        if (phase_reg == PH_CMP)
        begin
            upd_key_reg <= key_reg;
            upd_act_reg <= act_reg;
        end
        if (phase_reg == PH_UPD)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            head_reg   <= head_next;
            hvalid_reg <= (count_next != '0);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [SPQ_DATA_W-1:0] left_e;
            logic signed [SPQ_DATA_W-1:0] right_e;
            logic                         left_g;

            if (gi == 0)
            begin : g_first
                assign left_e = upd_key_reg;
                assign left_g = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = ent[gi-1];
                assign left_g = ge_vec[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_e = ent[gi];
            end
            else
            begin : g_inner
                assign right_e = ent[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .occupied    (CW'(gi) < count_reg),
                .cmp_key     (key_reg),
                .ins_key     (upd_key_reg),
                .left_entry  (left_e),
                .left_ge     (left_g),
                .right_entry (right_e),
                .entry       (ent[gi]),
                .entry_next  (ent_next[gi]),
                .ge          (ge_vec[gi]),
                .eq          (eq_vec[gi])
            );

            assign bnd_vec[gi] = ge_vec[gi] && !left_g;
        end
    endgenerate

    always_comb
    begin
        bnd_idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (bnd_vec[i])
            begin
                bnd_idx = bnd_idx | IW'(i);
            end
        end
    end

    assign found = |(bnd_vec & eq_vec);

    always_comb
    begin
        op_upd      = OP_HOLD;
        status_next = ST_NOT_FOUND;
        pos_next    = '0;
        count_next  = count_reg;
        case (action_t'(upd_act_reg))
            ACT_INSERT:
            begin
                if (count_reg == CW'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    op_upd      = OP_INSERT;
                    status_next = ST_DONE;
                    pos_next    = bnd_idx;
                    count_next  = count_reg + CW'(1);
                end
            end
            ACT_REMOVE:
            begin
                if (found)
                begin
                    op_upd      = OP_REMOVE;
                    status_next = ST_DONE;
                    pos_next    = bnd_idx;
                    count_next  = count_reg - CW'(1);
                end
            end
            ACT_FIND:
            begin
                if (found)
                begin
                    status_next = ST_DONE;
                    pos_next    = bnd_idx;
                end
            end
            default:
            begin
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    assign head_next = (count_next != '0) ? ent_next[0] : '0;

    assign pos_wide = {4'b0, pos_reg};
    assign cnt_wide = {5'b0, count_reg};

    assign done        = done_reg;
    assign status      = status_reg;
    assign position    = pos_wide[3:0];
    assign head_value  = head_reg;
    assign head_valid  = hvalid_reg;
    assign entry_count = cnt_wide[4:0];

    `SPQ_ASSERT_NXT(a_done_after_upd, phase_reg == PH_UPD, done_reg, "done must follow update")
    `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY), "count beyond capacity")
    `SPQ_ASSERT_IMP(a_full_status, done_reg && status_reg == ST_FULL,
                    count_reg == CW'(CAPACITY), "full status with free slots")
    `SPQ_ASSERT_IMP(a_head_valid, done_reg, hvalid_reg == (count_reg != '0),
                    "head valid disagrees with count")

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for sorted_priority_queue: directed table, then random requests.
// Depends on spq_pkg and the sorted_priority_queue RTL; carries its own queue model.
`timescale 1ns / 1ps

module testbench;

    import spq_pkg::*;

    localparam int          DEPTH       = SPQ_CAPACITY;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;
    localparam int          RANDOM_REQS = 750;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         position;
        logic signed [31:0] head_value;
        logic               head_valid;
        logic [4:0]         entry_count;
    } queue_result_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
        logic               typed;
        queue_result_t      want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         action;
    logic signed [31:0] value;
    logic               done;
    logic [1:0]         status;
    logic [3:0]         position;
    logic signed [31:0] head_value;
    logic               head_valid;
    logic [4:0]         entry_count;

    logic signed [31:0] model_entries [DEPTH];
    int                 model_count;
    queue_result_t      expected_results [$];
    stim_row_t          directed [$];
    logic signed [31:0] key_pool [24];
    int                 mismatches;

    sorted_priority_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .value       (value),
        .done        (done),
        .status      (status),
        .position    (position),
        .head_value  (head_value),
        .head_valid  (head_valid),
        .entry_count (entry_count)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report(input string what);
        if (mismatches < 40)
            $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic queue_result_t apply_queue_op(input logic [1:0] act,
                                                     input logic signed [31:0] val);
        queue_result_t r;
        int            at;
        r.status   = ST_NOT_FOUND;
        r.position = '0;
        at         = 0;
        if (act == ACT_INSERT) begin
            if (model_count >= DEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                while (at < model_count && model_entries[at] < val)
                    at++;
                for (int i = model_count; i > at; i--)
                    model_entries[i] = model_entries[i - 1];
                model_entries[at] = val;
                model_count++;
                r.status   = ST_DONE;
                r.position = 4'(at);
            end
        end
        else if (act == ACT_REMOVE || act == ACT_FIND) begin
            while (at < model_count && model_entries[at] != val)
                at++;
            if (at < model_count) begin
                if (act == ACT_REMOVE) begin
                    for (int i = at; i + 1 < model_count; i++)
                        model_entries[i] = model_entries[i + 1];
                    model_count--;
                end
                r.status   = ST_DONE;
                r.position = 4'(at);
            end
        end
        r.head_valid  = (model_count > 0);
        r.head_value  = (model_count > 0) ? model_entries[0] : '0;
        r.entry_count = 5'(model_count);
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] act, input logic signed [31:0] val);
        stim_row_t r;
        r        = '0;
        r.action = act;
        r.value  = val;
        directed.push_back(r);
    endfunction

    function automatic void add_typed(input logic [1:0] act, input logic signed [31:0] val,
                                      input logic [1:0] st, input logic [3:0] pos,
                                      input logic signed [31:0] hv, input logic hvld,
                                      input logic [4:0] cnt);
        stim_row_t r;
        r        = '0;
        r.action = act;
        r.value  = val;
        r.typed  = 1'b1;
        r.want   = '{st, pos, hv, hvld, cnt};
        directed.push_back(r);
    endfunction

    // request is accepted at the first rising edge with busy low
    task automatic send_request(input logic [1:0] act, input logic signed [31:0] val,
                                input logic typed, input queue_result_t want);
        queue_result_t predicted;
        start  <= 1'b1;
        action <= act;
        value  <= val;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_queue_op(act, val);
        expected_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        queue_result_t want;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                report("result with no request pending");
            end
            else begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report($sformatf("status %0d, want %0d", status, want.status));
                if (position !== want.position)
                    report($sformatf("position %0d, want %0d", position, want.position));
                if (head_value !== want.head_value)
                    report($sformatf("head_value %0d, want %0d", head_value, want.head_value));
                if (head_valid !== want.head_valid)
                    report($sformatf("head_valid %0b, want %0b", head_valid, want.head_valid));
                if (entry_count !== want.entry_count)
                    report($sformatf("entry_count %0d, want %0d", entry_count,
                                     want.entry_count));
            end
        end
    end

    initial
    begin
        logic               filling;
        logic               quiet;
        logic [1:0]         act;
        logic signed [31:0] val;
        int                 pick;

        rst_n       = 1'b0;
        start       = 1'b0;
        action      = ACT_INSERT;
        value       = '0;
        mismatches  = 0;
        model_count = 0;
        foreach (model_entries[i])
            model_entries[i] = '0;

        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        key_pool[4] = 32'sd1;
        for (int i = 5; i < 24; i++)
            key_pool[i] = (i < 14) ? $signed(32'($urandom_range(40, 0)) - 32'd20) : $urandom;

        // empty store, unused action, extremes, duplicates, full store
        add_typed(ACT_FIND,   32'sd0, ST_NOT_FOUND, 4'd0, 32'sd0, 1'b0, 5'd0);
        add_typed(ACT_REMOVE, 32'sd5, ST_NOT_FOUND, 4'd0, 32'sd0, 1'b0, 5'd0);
        add_typed(ACT_UNUSED, -32'sd1, ST_NOT_FOUND, 4'd0, 32'sd0, 1'b0, 5'd0);
        add_typed(ACT_INSERT, KEY_MIN, ST_DONE, 4'd0, KEY_MIN, 1'b1, 5'd1);
        add_typed(ACT_INSERT, KEY_MAX, ST_DONE, 4'd1, KEY_MIN, 1'b1, 5'd2);
        add_row(ACT_INSERT, 32'sd0);
        add_row(ACT_INSERT, -32'sd1);
        add_row(ACT_INSERT, 32'sd0);
        add_row(ACT_FIND, 32'sd0);
        add_row(ACT_REMOVE, KEY_MAX);
        add_row(ACT_FIND, KEY_MAX);
        for (int i = 0; i < 12; i++)
            add_row(ACT_INSERT, 32'sd100 * (i % 6) - 32'sd250);
        add_typed(ACT_INSERT, 32'sd7, ST_FULL, 4'd0, KEY_MIN, 1'b1, 5'd16);
        add_typed(ACT_UNUSED, KEY_MIN, ST_NOT_FOUND, 4'd0, KEY_MIN, 1'b1, 5'd16);
        add_row(ACT_REMOVE, KEY_MIN);

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i]) begin
            send_request(directed[i].action, directed[i].value, directed[i].typed,
                         directed[i].want);
            idle_gap(($urandom_range(2, 0) == 0) ? 0 : $urandom_range(15, 0));
        end

        filling = 1'b1;
        quiet   = 1'b0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 40 == 0) begin
                filling = ~filling;
                quiet   = ($urandom_range(3, 0) == 0);
            end
            pick = $urandom_range(99, 0);
            if (pick < 5)
                act = ACT_UNUSED;
            else if (pick < 20)
                act = ACT_FIND;
            else if (pick < (filling ? 70 : 40))
                act = ACT_INSERT;
            else
                act = ACT_REMOVE;

            pick = $urandom_range(99, 0);
            if (pick < 30 && model_count > 0 && act != ACT_INSERT)
                val = model_entries[$urandom_range(model_count - 1, 0)];
            else if (pick < 80)
                val = key_pool[$urandom_range(23, 0)];
            else
                val = $urandom;

            send_request(act, val, 1'b0, '0);
            idle_gap(quiet ? 0 : $urandom_range(15, 0));
        end
        start <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
